// File: sv/esd_pkg.sv
`timescale 1ns / 1ps

package esd_pkg;

	// Character codes that the decoder treats specially
	localparam logic [15:0] CH_BACKSLASH = 16'h005c;
	localparam logic [15:0] CH_X         = 16'h0078;
	localparam logic [15:0] CH_ZERO      = 16'h0030;
	localparam logic [15:0] CH_NINE      = 16'h0039;
	localparam logic [15:0] CH_ESC       = 16'h001b;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_HEX  = 2'd1,
		MODE_OCT  = 2'd2
	} mode_t;

	// One input character
	typedef struct packed {
		logic [15:0] in_char;
		logic        in_last;
	} chr_t;

	// One decoded result
	typedef struct packed {
		logic [15:0] out_char;
		logic        has_char;
		logic        out_end;
	} dec_t;

	// Results of one accepted character, handed to the output buffer
	typedef struct packed {
		logic       push;
		logic [1:0] count;
		dec_t       r0;
		dec_t       r1;
	} dec_bundle_t;

	// Escape state carried from one character to the next
	typedef struct packed {
		logic        pending;
		mode_t       mode;
		logic [31:0] acc;
		logic        invalid;
		logic        seen;
	} esc_state_t;

	localparam esc_state_t ESC_IDLE = '{
		pending: 1'b0, mode: MODE_NONE, acc: 32'd0, invalid: 1'b0, seen: 1'b0
	};

	// Single-letter escapes: returns {hit, code}
	function automatic logic [16:0] simple_escape(input logic [15:0] c);
		logic [16:0] r;
		begin
			case (c)
				16'h0061: r = {1'b1, 16'h0007};
				16'h0062: r = {1'b1, 16'h0008};
				16'h0065: r = {1'b1, CH_ESC};
				16'h0066: r = {1'b1, 16'h000c};
				16'h006e: r = {1'b1, 16'h000a};
				16'h0072: r = {1'b1, 16'h000d};
				16'h0074: r = {1'b1, 16'h0009};
				16'h0022: r = {1'b1, 16'h0022};
				16'h0027: r = {1'b1, 16'h0027};
				16'h005c: r = {1'b1, CH_BACKSLASH};
				default:  r = {1'b0, 16'h0000};
			endcase
			return r;
		end
	endfunction

	// Hex digit: returns {ok, value}
	function automatic logic [4:0] hex_digit(input logic [15:0] c);
		logic [4:0] r;
		begin
			if (c inside {[16'h0030:16'h0039]}) begin
				r = {1'b1, c[3:0]};
			end else if (c inside {[16'h0061:16'h0066], [16'h0041:16'h0046]}) begin
				r = {1'b1, c[3:0] + 4'd9};
			end else begin
				r = 5'd0;
			end
			return r;
		end
	endfunction

	function automatic dec_t put_char(input logic [15:0] c);
		dec_t r;
		begin
			r.out_char = c;
			r.has_char = 1'b1;
			r.out_end  = 1'b0;
			return r;
		end
	endfunction

endpackage

// File: sv/escape_sequence_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// chr      in         chr_valid / chr_stall  chr_t: in_char, in_last
// dec      out        dec_valid / dec_stall  dec_t: out_char, has_char, out_end
//
// One character request is decoded per cycle while the buffer has room: one
// combinational pass from the escape state registers into a two-entry result
// buffer; results appear the cycle after their request, and requests can follow
// back to back. A request yielding two results (an unknown escape with its
// backslash, or a numeric value and its ending character) holds chr_stall until
// the second is taken. arst_n clears all but the result slots; chr_stall tracks dec_stall.
module escape_sequence_decoder import esd_pkg::*; #(
	parameter int CHAR_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic chr_valid,
	output logic chr_stall,
	input  chr_t chr,
	output logic dec_valid,
	input  logic dec_stall,
	output dec_t dec
);

	logic        ready;
	logic        fire;
	dec_bundle_t bundle;

	// A request is taken whenever the result buffer will have room for it.
	assign chr_stall = !ready;
	assign fire      = chr_valid && ready;

	esd_core #(
		.CHAR_BITS(CHAR_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.chr    (chr),
		.bundle (bundle)
	);

	esd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.ready     (ready),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec       (dec)
	);

`ifndef ASSERT_OFF
	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec.has_char |-> dec.out_end && dec.out_char == 16'd0)
		else $error("bare result is not a clean end marker");
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !dec_valid)
		else $error("result presented straight out of reset");
	a_stall_with_pair: assert property (@(posedge clk) disable iff (!arst_n)
		fire && bundle.count == 2'd2 |=> chr_stall)
		else $error("request taken while a second result is still queued");
`endif

endmodule

// File: sv/esd_core.sv
`timescale 1ns / 1ps

module esd_core import esd_pkg::*; #(
	parameter int CHAR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  chr_t        chr,
	output dec_bundle_t bundle
);

	localparam int KEEP_BITS = (CHAR_BITS < 16) ? CHAR_BITS : 16;
	localparam logic [31:0] VALUE_MASK = (32'h1 << KEEP_BITS) - 32'h1;

	esc_state_t st_q, st_d;
	logic [4:0]  hd;
	logic [16:0] se;
	logic        dec_digit, is_digit, emit;
	logic [31:0] value;
	logic [1:0]  n;
	dec_t        r0, r1;

	assign hd        = hex_digit(chr.in_char);
	assign se        = simple_escape(chr.in_char);
	assign dec_digit = (chr.in_char >= CH_ZERO) && (chr.in_char <= CH_NINE);
	assign value     = st_q.acc & VALUE_MASK;

	always_comb begin
		st_d     = st_q;
		n        = 2'd0;
		r0       = '0;
		r1       = '0;
		is_digit = 1'b0;
		emit     = 1'b0;
		if (!st_q.pending) begin
			if (chr.in_char == CH_BACKSLASH) begin
				st_d         = ESC_IDLE;
				st_d.pending = 1'b1;
			end else begin
				r0 = put_char(chr.in_char);
				n  = 2'd1;
			end
		end else if (st_q.mode == MODE_HEX || st_q.mode == MODE_OCT) begin
			is_digit = (st_q.mode == MODE_HEX) ? hd[4] : dec_digit;
			if (is_digit) begin
				st_d.seen = 1'b1;
				if (!st_q.invalid) begin
					if (st_q.mode == MODE_HEX) begin
						if (|st_q.acc[31:28]) begin
							st_d.invalid = 1'b1;
						end else begin
							st_d.acc = {st_q.acc[27:0], hd[3:0]};
						end
					end else if (chr.in_char[3] || (|st_q.acc[31:29])) begin
						st_d.invalid = 1'b1;
					end else begin
						st_d.acc = {st_q.acc[28:0], chr.in_char[2:0]};
					end
				end
			end else begin
				// The escape ends; a backslash starts a new one, else the ender is plain text.
				emit = st_q.seen && !st_q.invalid;
				st_d = ESC_IDLE;
				if (emit) begin
					r0 = put_char(value[15:0]);
					n  = 2'd1;
				end
				if (chr.in_char == CH_BACKSLASH) begin
					st_d.pending = 1'b1;
				end else if (emit) begin
					r1 = put_char(chr.in_char);
					n  = 2'd2;
				end else begin
					r0 = put_char(chr.in_char);
					n  = 2'd1;
				end
			end
		end else begin
			if (se[16]) begin
				r0   = put_char(se[15:0]);
				n    = 2'd1;
				st_d = ESC_IDLE;
			end else if (chr.in_char == CH_X) begin
				st_d.mode    = MODE_HEX;
				st_d.acc     = 32'd0;
				st_d.invalid = 1'b0;
				st_d.seen    = 1'b0;
			end else if (dec_digit) begin
				st_d.mode    = MODE_OCT;
				st_d.acc     = {28'd0, chr.in_char[3:0]};
				st_d.invalid = chr.in_char[3];
				st_d.seen    = 1'b1;
			end else begin
				r0   = put_char(CH_BACKSLASH);
				r1   = put_char(chr.in_char);
				n    = 2'd2;
				st_d = ESC_IDLE;
			end
		end
		if (chr.in_last) begin
			if (n == 2'd0) begin
				r0.out_end = 1'b1;
				n          = 2'd1;
			end else if (n == 2'd1) begin
				r0.out_end = 1'b1;
			end else begin
				r1.out_end = 1'b1;
			end
			st_d = ESC_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ESC_IDLE;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	assign bundle.push  = fire && (n != 2'd0);
	assign bundle.count = n;
	assign bundle.r0    = r0;
	assign bundle.r1    = r1;

`ifndef ASSERT_OFF
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && chr.in_last |=> !st_q.pending && st_q.mode == MODE_NONE)
		else $error("escape state not cleared after final character");
	a_mode_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode != MODE_NONE |-> st_q.pending)
		else $error("numeric mode without a pending escape");
	a_last_yields: assert property (@(posedge clk) disable iff (!arst_n)
		fire && chr.in_last |-> bundle.push)
		else $error("final character produced no result");
`endif

endmodule

// File: sv/esd_obuf.sv
`timescale 1ns / 1ps

module esd_obuf import esd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dec_bundle_t bundle,
	output logic        ready,
	output logic        dec_valid,
	input  logic        dec_stall,
	output dec_t        dec
);

	dec_t       slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign dec_valid = (cnt_q != 2'd0);
	assign dec       = slot0_q;
	assign pop       = dec_valid && !dec_stall;
	// Room for a new request once the buffer will be empty at this edge.
	assign ready     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (bundle.push) begin
			cnt_q <= bundle.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bundle.push) begin
			slot0_q <= bundle.r0;
			slot1_q <= bundle.r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		bundle.push |-> ready)
		else $error("result pushed into an occupied buffer");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && pop |=> cnt_q == 2'd1)
		else $error("second result lost while draining");
`endif

endmodule
